// ===== rtl/gcca_pkg.sv =====
// Package for the greedy constraint color allocator.
// Holds sizes, the controller state type and the command and status structs.
// Has no dependencies; used by every module of the allocator.
package gcca_pkg;

    localparam int BODIES          = 1024;
    localparam int BODY_W          = $clog2(BODIES);
    localparam int COLORS          = 32;
    localparam int COLOR_W         = $clog2(COLORS);
    localparam int LANES_PER_BLOCK = 4;
    localparam int LANE_W          = $clog2(LANES_PER_BLOCK);
    localparam int ROW_CAPACITY    = 4096;
    localparam int CNT_W           = $clog2(ROW_CAPACITY) + 1;
    localparam int IDX_W           = 12;
    localparam int BLOCK_W         = 10;
    localparam int MAX_ROWS        = 8;
    localparam int ROWS_W          = 4;
    localparam int K_W             = $clog2(MAX_ROWS);

    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_ROW,
        ST_WB0,
        ST_WB1
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture a new add request
        logic clr_start;  // empty the counters and restart the clear sweep
        logic clr_step;   // zero one body set
        logic rd;         // read both body sets into the working registers
        logic row;        // place one row and load the result register
        logic wb0;        // write back the first body's set
        logic wb1;        // write back the second body's set
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rows_zero;  // the captured request places no row
        logic row_last;   // the next row is the final one of the request
        logic out_free;   // the result register can take a new result
        logic clr_last;   // the sweep is at the last body
    } status_t;

endpackage

// ===== rtl/gcca_ctrl.sv =====
// Controller state machine of the greedy constraint color allocator.
// Depends on gcca_pkg; drives commands into gcca_datapath.
module gcca_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_kind,
    output logic             s_ready,
    input  gcca_pkg::status_t sts,
    output gcca_pkg::cmd_t   cmd
);
    import gcca_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_kind == KIND_CLEAR) begin
                        cmd.clr_start = 1'b1;
                        state_next    = ST_CLEAR;
                    end else begin
                        cmd.load   = 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                cmd.rd = 1'b1;
                state_next = sts.rows_zero ? ST_IDLE : ST_ROW;
            end
            ST_ROW: begin
                if (sts.out_free) begin
                    cmd.row = 1'b1;
                    if (sts.row_last) begin
                        state_next = ST_WB0;
                    end
                end
            end
            ST_WB0: begin
                cmd.wb0    = 1'b1;
                state_next = ST_WB1;
            end
            ST_WB1: begin
                cmd.wb1    = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/gcca_datapath.sv =====
// Datapath of the greedy constraint color allocator: body set memory,
// working set registers, color slot counters and the result register.
// Depends on gcca_pkg; commanded by gcca_ctrl.
module gcca_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gcca_pkg::cmd_t                cmd,
    output gcca_pkg::status_t             sts,
    input  logic [gcca_pkg::BODY_W-1:0]   s_first_body,
    input  logic [gcca_pkg::BODY_W-1:0]   s_second_body,
    input  logic [gcca_pkg::ROWS_W-1:0]   s_row_count,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_colored,
    output logic [gcca_pkg::COLOR_W-1:0]  m_color,
    output logic [gcca_pkg::BLOCK_W-1:0]  m_block_index,
    output logic [gcca_pkg::LANE_W-1:0]   m_lane,
    output logic [gcca_pkg::IDX_W-1:0]    m_sequential_index,
    output logic [gcca_pkg::IDX_W-1:0]    m_row_index,
    output logic                          m_full_res,
    output logic                          m_last
);
    import gcca_pkg::*;

    function automatic logic [COLOR_W-1:0] lowest_set(input logic [COLORS-1:0] v);
        logic [COLOR_W-1:0] r;
        r = '0;
        for (int i = COLORS - 1; i >= 0; i--) begin
            if (v[i]) r = COLOR_W'(i);
        end
        return r;
    endfunction

    logic [COLORS-1:0] body_mem [BODIES];

    logic [BODY_W-1:0]  b0_reg, b1_reg;
    logic [ROWS_W-1:0]  rows_reg;
    logic [K_W-1:0]     k_reg;
    logic [COLORS-1:0]  s0_reg, s1_reg;
    logic [BODY_W-1:0]  clr_addr_reg;
    logic [CNT_W-1:0]   slot_cnt_reg [COLORS];
    logic [CNT_W-1:0]   seq_cnt_reg;
    logic [CNT_W-1:0]   total_reg;

    logic               out_valid_reg;
    logic               colored_reg, full_reg, last_reg;
    logic [COLOR_W-1:0] color_reg;
    logic [BLOCK_W-1:0] block_reg;
    logic [LANE_W-1:0]  lane_reg;
    logic [IDX_W-1:0]   seq_idx_reg, row_idx_reg;

    logic [COLORS-1:0]  free_set;
    logic               any_free;
    logic [COLOR_W-1:0] pick;
    logic [CNT_W-1:0]   slot;
    logic               store_full;
    logic               place_color;
    logic [COLORS-1:0]  pick_bit;
    logic [ROWS_W-1:0]  rows_eff;

    assign rows_eff    = (s_row_count > ROWS_W'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS) : s_row_count;
    assign free_set    = ~(s0_reg | s1_reg);
    assign any_free    = |free_set;
    assign pick        = lowest_set(free_set);
    assign slot        = slot_cnt_reg[pick];
    assign store_full  = (total_reg >= CNT_W'(ROW_CAPACITY));
    assign place_color = cmd.row && !store_full && any_free;
    assign pick_bit    = COLORS'(1) << pick;

    assign sts.rows_zero = (rows_reg == '0);
    assign sts.row_last  = ((ROWS_W'(k_reg) + ROWS_W'(1)) == rows_reg);
    assign sts.out_free  = !out_valid_reg || m_ready;
    assign sts.clr_last  = (clr_addr_reg == BODY_W'(BODIES - 1));

    // Body set memory: one write port, two registered read ports.
    always_ff @(posedge aclk) begin
        if (cmd.clr_step) begin
            body_mem[clr_addr_reg] <= '0;
        end else if (cmd.wb0) begin
            body_mem[b0_reg] <= s0_reg;
        end else if (cmd.wb1) begin
            body_mem[b1_reg] <= s1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            s0_reg <= body_mem[b0_reg];
            s1_reg <= body_mem[b1_reg];
        end else if (place_color) begin
            s0_reg <= s0_reg | pick_bit;
            s1_reg <= s1_reg | pick_bit;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            b0_reg   <= s_first_body;
            b1_reg   <= s_second_body;
            rows_reg <= rows_eff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= '0;
        end else if (cmd.load) begin
            k_reg <= '0;
        end else if (cmd.row) begin
            k_reg <= k_reg + K_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clr_start) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_addr_reg <= clr_addr_reg + BODY_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clr_start) begin
            for (int i = 0; i < COLORS; i++) begin
                slot_cnt_reg[i] <= '0;
            end
            seq_cnt_reg <= '0;
            total_reg   <= '0;
        end else if (cmd.row && !store_full) begin
            total_reg <= total_reg + CNT_W'(1);
            if (any_free) begin
                slot_cnt_reg[pick] <= slot + CNT_W'(1);
            end else begin
                seq_cnt_reg <= seq_cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.row) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.row) begin
            colored_reg <= place_color;
            color_reg   <= place_color ? pick : '0;
            block_reg   <= place_color ? BLOCK_W'(slot >> LANE_W) : '0;
            lane_reg    <= place_color ? slot[LANE_W-1:0] : '0;
            seq_idx_reg <= (!store_full && !any_free) ? seq_cnt_reg[IDX_W-1:0] : '0;
            row_idx_reg <= store_full ? '0 : total_reg[IDX_W-1:0];
            full_reg    <= store_full;
            last_reg    <= sts.row_last;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_colored          = colored_reg;
    assign m_color            = color_reg;
    assign m_block_index      = block_reg;
    assign m_lane             = lane_reg;
    assign m_sequential_index = seq_idx_reg;
    assign m_row_index        = row_idx_reg;
    assign m_full_res         = full_reg;
    assign m_last             = last_reg;

    a_row_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.row |-> (!out_valid_reg || m_ready))
        else $error("row placed while the result register was still held");

    a_total_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= CNT_W'(ROW_CAPACITY))
        else $error("row total went past capacity");

    a_seq_within_total: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_cnt_reg <= total_reg)
        else $error("sequential count exceeds row total");

    a_full_row_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.row && store_full) |=> $stable(total_reg) && $stable(seq_cnt_reg))
        else $error("a counter moved on a row dropped at capacity");

endmodule

// ===== rtl/greedy_constraint_color_allocator_unit.sv =====
// Top level of the greedy constraint color allocator.
// Depends on gcca_pkg, gcca_ctrl and gcca_datapath.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    kind, first_body, second_body, row_count
//   m_        out        m_valid/m_ready    colored, color, block_index, lane,
//                                           sequential_index, row_index, full_res, last
//
// An add request is accepted, then both body sets are read from the single set
// memory, each row goes through the priority pick once the result register is free,
// and the two sets are written back one after the other over the one write port.
// A request with zero rows returns to idle after the read. A clear request, and reset
// itself, starts a sweep that zeroes one body set per cycle until all BODIES sets are
// zeroed, during which no transfer is accepted on the input channel.
// A stalled result register holds the next row; finished results wait there
// while the controller returns to idle and takes the next request.
//
// Each row picks the lowest color free in both bodies' sets, marks it in the
// working copies of both sets and takes the next slot of that color. When no
// color is free the row goes to the sequential list. Once the row total has
// reached capacity, rows are reported as full and change no body set or counter.
module greedy_constraint_color_allocator_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic [gcca_pkg::BODY_W-1:0]   s_first_body,
    input  logic [gcca_pkg::BODY_W-1:0]   s_second_body,
    input  logic [gcca_pkg::ROWS_W-1:0]   s_row_count,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_colored,
    output logic [gcca_pkg::COLOR_W-1:0]  m_color,
    output logic [gcca_pkg::BLOCK_W-1:0]  m_block_index,
    output logic [gcca_pkg::LANE_W-1:0]   m_lane,
    output logic [gcca_pkg::IDX_W-1:0]    m_sequential_index,
    output logic [gcca_pkg::IDX_W-1:0]    m_row_index,
    output logic                          m_full_res,
    output logic                          m_last
);
    import gcca_pkg::*;

    cmd_t    cmd;
    status_t sts;

    // The controller sequences each request; it never looks at payload bits
    // other than the kind of the request being offered.
    gcca_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_kind),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // The datapath owns all state but the controller's: the body set memory, the
    // per-color slot counters, the list and row totals, and the result register.
    gcca_datapath u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .s_first_body       (s_first_body),
        .s_second_body      (s_second_body),
        .s_row_count        (s_row_count),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_colored          (m_colored),
        .m_color            (m_color),
        .m_block_index      (m_block_index),
        .m_lane             (m_lane),
        .m_sequential_index (m_sequential_index),
        .m_row_index        (m_row_index),
        .m_full_res         (m_full_res),
        .m_last             (m_last)
    );

endmodule

// ===== sim/gcca_checker.sv =====
// Checker for the greedy constraint color allocator: watches both channels,
// predicts every row result and compares it field by field.
// Depends on gcca_pkg for sizes and request kinds.
module gcca_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          s_kind,
    input  logic [gcca_pkg::BODY_W-1:0]   s_first_body,
    input  logic [gcca_pkg::BODY_W-1:0]   s_second_body,
    input  logic [gcca_pkg::ROWS_W-1:0]   s_row_count,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic                          m_colored,
    input  logic [gcca_pkg::COLOR_W-1:0]  m_color,
    input  logic [gcca_pkg::BLOCK_W-1:0]  m_block_index,
    input  logic [gcca_pkg::LANE_W-1:0]   m_lane,
    input  logic [gcca_pkg::IDX_W-1:0]    m_sequential_index,
    input  logic [gcca_pkg::IDX_W-1:0]    m_row_index,
    input  logic                          m_full_res,
    input  logic                          m_last,
    output int                            fail_count,
    output int                            pending,
    output int                            rows_checked,
    output int                            colored_rows,
    output int                            sequential_rows,
    output int                            full_rows
);
    timeunit 1ns;
    timeprecision 1ps;

    import gcca_pkg::*;

    typedef struct packed {
        logic               colored;
        logic [COLOR_W-1:0] color;
        logic [BLOCK_W-1:0] block_index;
        logic [LANE_W-1:0]  lane;
        logic [IDX_W-1:0]   seq_index;
        logic [IDX_W-1:0]   row_index;
        logic               full;
        logic               last;
    } row_result_t;

    row_result_t       placements_q[$];
    logic [COLORS-1:0] used_colors[BODIES];
    logic [CNT_W-1:0]  color_slots[COLORS];
    logic [CNT_W-1:0]  seq_rows;
    logic [CNT_W-1:0]  placed_rows;

    task automatic clear_stores();
        foreach (used_colors[b]) used_colors[b] = '0;
        foreach (color_slots[c]) color_slots[c] = '0;
        seq_rows    = '0;
        placed_rows = '0;
    endtask

    // Places the rows of one request the way the allocator should and queues
    // one expected result per row.
    task automatic place_rows(input logic kind, input logic [BODY_W-1:0] b0,
                              input logic [BODY_W-1:0] b1,
                              input logic [ROWS_W-1:0] requested);
        int                rows;
        int                pick;
        logic [COLORS-1:0] free_set;
        logic [CNT_W-1:0]  slot;
        row_result_t       r;
        if (kind == KIND_CLEAR) begin
            clear_stores();
            return;
        end
        rows = (requested > MAX_ROWS) ? MAX_ROWS : int'(requested);
        for (int k = 0; k < rows; k++) begin
            r = '0;
            if (placed_rows >= ROW_CAPACITY) begin
                // Saturated: the row is dropped and nothing moves.
                r.full = 1'b1;
            end else begin
                free_set = ~(used_colors[b0] | used_colors[b1]);
                pick = -1;
                for (int c = COLORS - 1; c >= 0; c--) begin
                    if (free_set[c]) pick = c;
                end
                r.row_index = IDX_W'(placed_rows);
                if (pick >= 0) begin
                    slot = color_slots[pick];
                    used_colors[b0][pick] = 1'b1;
                    used_colors[b1][pick] = 1'b1;
                    r.colored     = 1'b1;
                    r.color       = COLOR_W'(pick);
                    r.block_index = BLOCK_W'(slot / LANES_PER_BLOCK);
                    r.lane        = LANE_W'(slot % LANES_PER_BLOCK);
                    color_slots[pick] = slot + CNT_W'(1);
                end else begin
                    r.seq_index = IDX_W'(seq_rows);
                    seq_rows    = seq_rows + CNT_W'(1);
                end
                placed_rows = placed_rows + CNT_W'(1);
            end
            r.last = (k == rows - 1);
            placements_q.push_back(r);
        end
    endtask

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    task automatic check_row();
        row_result_t want;
        if (placements_q.size() == 0) begin
            $error("row result transfer with no row expected");
            fail_count++;
            return;
        end
        want = placements_q.pop_front();
        check_field("colored", 32'(want.colored), 32'(m_colored));
        check_field("color", 32'(want.color), 32'(m_color));
        check_field("block_index", 32'(want.block_index), 32'(m_block_index));
        check_field("lane", 32'(want.lane), 32'(m_lane));
        check_field("sequential_index", 32'(want.seq_index), 32'(m_sequential_index));
        check_field("row_index", 32'(want.row_index), 32'(m_row_index));
        check_field("full_res", 32'(want.full), 32'(m_full_res));
        check_field("last", 32'(want.last), 32'(m_last));
        rows_checked++;
        if (want.full) full_rows++;
        else if (want.colored) colored_rows++;
        else sequential_rows++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_stores();
            placements_q.delete();
        end else begin
            if (m_valid && m_ready) check_row();
            if (s_valid && s_ready) begin
                place_rows(s_kind, s_first_body, s_second_body, s_row_count);
            end
        end
        pending <= placements_q.size();
    end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the greedy constraint color allocator: drives requests,
// applies random back-pressure and gives the verdict.
// Depends on gcca_pkg, greedy_constraint_color_allocator_unit and gcca_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gcca_pkg::*;

    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 11;
    localparam int RANDOM_REQUESTS = 130;
    localparam int POOL_SIZE       = 6;
    localparam int DRAIN_LIMIT     = 20000;
    // After the last row result the write-back of both body sets can still be
    // in flight; the settle time lets that work finish.
    localparam int SETTLE_CYCLES   = 32;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_kind = KIND_ADD;
    logic [BODY_W-1:0]  s_first_body = '0;
    logic [BODY_W-1:0]  s_second_body = '0;
    logic [ROWS_W-1:0]  s_row_count = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_colored;
    logic [COLOR_W-1:0] m_color;
    logic [BLOCK_W-1:0] m_block_index;
    logic [LANE_W-1:0]  m_lane;
    logic [IDX_W-1:0]   m_sequential_index;
    logic [IDX_W-1:0]   m_row_index;
    logic               m_full_res;
    logic               m_last;

    int fail_count;
    int pending;
    int rows_checked;
    int colored_rows;
    int sequential_rows;
    int full_rows;

    // When set, the sender or the receiver runs without any idle cycles.
    bit s_calm;
    bit m_calm;
    int requests_sent;
    int clears_sent;
    logic [BODY_W-1:0] body_pool[POOL_SIZE];

    greedy_constraint_color_allocator_unit uut (.*);

    gcca_checker chk (.*);

    always #HALF_PERIOD aclk = ~aclk;

    // Watchdog. The slowest legal run, with every stall at its longest, stays
    // well below this.
    initial begin
        #(30_000_000);
        $display("tb: FAIL");
        $finish;
    end

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int idle_len(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: ready stays high for a random run of cycles, then drops
    // for a random stall. A zero-length stall keeps ready high.
    initial begin
        int stall;
        @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            stall = idle_len(m_calm);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    // Presents one request and returns at the edge where it is transferred.
    // Valid is only lowered when a gap precedes the request, so back-to-back
    // requests keep valid high with a single assignment per edge.
    task automatic send_request(input logic kind, input int b0, input int b1,
                                input int rows);
        int gap;
        gap = idle_len(s_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_kind        <= kind;
        s_first_body  <= BODY_W'(b0);
        s_second_body <= BODY_W'(b1);
        s_row_count   <= ROWS_W'(rows);
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
        if (kind == KIND_CLEAR) clears_sent++;
    endtask

    // Bodies are mostly drawn from a small pool so that their color sets
    // fill up and rows spill into the sequential list.
    function automatic int pick_body();
        if ($urandom_range(0, 9) < 7) return int'(body_pool[$urandom_range(0, POOL_SIZE - 1)]);
        return $urandom_range(0, BODIES - 1);
    endfunction

    initial begin
        int b0;
        int b1;
        int rows;
        int r;
        int waited;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        // The reset sweep holds s_ready low until every body set is zeroed; the first
        // transfer simply waits for it.

        // Directed part. Body index extremes and more rows than MAX_ROWS.
        send_request(KIND_ADD, 0, BODIES - 1, 15);
        send_request(KIND_ADD, BODIES - 1, 0, MAX_ROWS);
        // Both indices name the same body.
        send_request(KIND_ADD, 5, 5, MAX_ROWS);
        // A request with no rows gives no result.
        send_request(KIND_ADD, 5, 5, 0);
        // Five full requests on one pair use up all 32 colors, so the last
        // eight rows go to the sequential list.
        repeat (5) send_request(KIND_ADD, 10, 11, MAX_ROWS);
        send_request(KIND_ADD, 10, 11, 1);
        // One exhausted body is enough to force the sequential list.
        send_request(KIND_ADD, 10, 12, 4);
        // A clear empties every store; the next rows start again at color 0.
        send_request(KIND_CLEAR, 10, 11, 3);
        send_request(KIND_ADD, 10, 11, 3);
        send_request(KIND_ADD, 512, 511, 9);
        send_request(KIND_ADD, 0, 0, 1);

        // Row counts at, above and below the limit, then a clear and a short add.
        send_request(KIND_ADD, 3, 4, MAX_ROWS);
        send_request(KIND_ADD, 3, 4, 15);
        send_request(KIND_ADD, 3, 4, 0);
        send_request(KIND_CLEAR, 0, 0, 0);
        send_request(KIND_ADD, 3, 4, 2);

        // Random part: mostly adds on a small body pool with a few clears,
        // same-body pairs and out-of-range row counts mixed in.
        foreach (body_pool[p]) body_pool[p] = BODY_W'($urandom_range(0, BODIES - 1));
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            s_calm = (i % 40) >= 30;
            m_calm = (i % 50) < 8;
            r = $urandom_range(0, 99);
            if (r < 4) begin
                send_request(KIND_CLEAR, $urandom_range(0, BODIES - 1),
                             $urandom_range(0, BODIES - 1), $urandom_range(0, 15));
            end else begin
                b0 = pick_body();
                b1 = ($urandom_range(0, 9) == 0) ? b0 : pick_body();
                r = $urandom_range(0, 99);
                if (r < 10) rows = $urandom_range(MAX_ROWS + 1, 15);
                else if (r < 15) rows = 0;
                else rows = $urandom_range(1, MAX_ROWS);
                send_request(KIND_ADD, b0, b1, rows);
            end
        end
        s_valid <= 1'b0;

        // Drain: the pending count is registered in the checker, so take a clock step
        // before reading it, then wait for every queued row result.
        waited = 0;
        @(posedge aclk);
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("tb: %0d requests (%0d clears) gave %0d row results", requests_sent,
                 clears_sent, rows_checked);
        $display("tb: %0d rows colored, %0d sequential, %0d dropped at capacity",
                 colored_rows, sequential_rows, full_rows);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: PASS");
        end else begin
            if (pending != 0) $error("%0d expected row results never arrived", pending);
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
